### design/bdhr_pkg.sv
// ----------------------------------------------------------------------------
// bdhr_pkg: shared types and constants
// Widths, opcodes, register indexes and reset values for the button debounce
// block with hold and repeat events.
// ----------------------------------------------------------------------------
package bdhr_pkg;

  // Defaults for the top-level parameters.
  localparam int BUTTON_COUNT_DEFAULT = 7;
  localparam int QUEUE_DEPTH_DEFAULT  = 16;

  // Item opcodes.
  localparam int          OPCODE_W = 2;
  localparam logic [1:0]  OP_TICK  = 2'd0;
  localparam logic [1:0]  OP_POP   = 2'd1;
  localparam logic [1:0]  OP_CLEAR = 2'd2;

  // Configuration port.
  localparam int         CFG_INDEX_W   = 2;
  localparam int         CFG_DATA_W    = 16;
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_HOLD      = 2'd1;
  localparam logic [1:0] CFG_REPEAT    = 2'd2;

  localparam int DEBOUNCE_W = 8;
  localparam int AGE_W      = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd4;
  localparam logic [AGE_W-1:0]      HOLD_RESET     = 16'd100;
  localparam logic [AGE_W-1:0]      REPEAT_RESET   = 16'd25;

  // Saturation limits of the two counters.
  localparam logic [DEBOUNCE_W-1:0] STABLE_MAX = 8'hFF;
  localparam logic [AGE_W-1:0]      AGE_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [AGE_W-1:0]      hold_ticks;
    logic [AGE_W-1:0]      repeat_ticks;
  } cfg_t;

  // Decoded command kind; an unused opcode has all flags low.
  typedef struct packed {
    logic tick;
    logic pop;
    logic clear;
  } cmd_kind_t;

endpackage

### design/bdhr_front.sv
// ----------------------------------------------------------------------------
// bdhr_front: command intake
// Accepts input words, decodes the opcode and holds up to two decoded
// commands so the intake and the execution side stall independently.
// ----------------------------------------------------------------------------
module bdhr_front #(
  parameter int BUTTON_COUNT = bdhr_pkg::BUTTON_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [bdhr_pkg::OPCODE_W-1:0] opcode,
  input  logic [BUTTON_COUNT-1:0]       raw_buttons,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output bdhr_pkg::cmd_kind_t           cmd_kind,
  output logic [BUTTON_COUNT-1:0]       cmd_raw
);
  import bdhr_pkg::*;

  cmd_kind_t               kind_q [2];
  logic [BUTTON_COUNT-1:0] raw_q  [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;
  cmd_kind_t               decoded;
  logic                    push;
  logic                    pull;

  always_comb begin
    decoded.tick  = (opcode == OP_TICK);
    decoded.pop   = (opcode == OP_POP);
    decoded.clear = (opcode == OP_CLEAR);
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign cmd_valid  = (count != 2'd0);
  assign pull       = cmd_valid && cmd_ready;
  assign cmd_kind   = kind_q[rd_ptr];
  assign cmd_raw    = raw_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr] <= decoded;
      raw_q[wr_ptr]  <= raw_buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pull) rd_ptr <= ~rd_ptr;
      unique case ({push, pull})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/bdhr_back.sv
// ----------------------------------------------------------------------------
// bdhr_back: command execution
// Runs the debouncer, press tracking, hold and repeat timing and event ring
// buffer into a registered result word, one command per cycle unless stalled.
// ----------------------------------------------------------------------------
module bdhr_back #(
  parameter int BUTTON_COUNT = bdhr_pkg::BUTTON_COUNT_DEFAULT,
  parameter int QUEUE_DEPTH  = bdhr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bdhr_pkg::cfg_t                     cfg,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  bdhr_pkg::cmd_kind_t                cmd_kind,
  input  logic [BUTTON_COUNT-1:0]            cmd_raw,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic                               pop_valid,
  output logic [BUTTON_COUNT-1:0]            pop_buttons,
  output logic                               pop_is_hold,
  output logic [BUTTON_COUNT-1:0]            debounced_buttons,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   pending_events,
  output logic                               event_dropped
);
  import bdhr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Debounce and press state.
  logic [BUTTON_COUNT-1:0] last_sample,     last_sample_next;
  logic [DEBOUNCE_W-1:0]   stable_count,    stable_count_next;
  logic [BUTTON_COUNT-1:0] debounced_state, debounced_state_next;
  logic [BUTTON_COUNT-1:0] pressed_set,     pressed_set_next;
  logic                    hold_fired,      hold_fired_next;
  logic [AGE_W-1:0]        press_age,       press_age_next;

  // Event ring buffer; bit BUTTON_COUNT of an entry marks a hold event.
  logic [BUTTON_COUNT:0]   event_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]        write_pointer,   write_pointer_next;
  logic [PTR_W-1:0]        read_pointer,    read_pointer_next;
  logic [CNT_W-1:0]        queued_count,    queued_count_next;

  logic                    fire;
  logic                    ev_put;
  logic [BUTTON_COUNT:0]   ev_word;
  logic                    mem_we;
  logic                    pop_hit;
  logic                    dropped;
  logic                    queue_full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign cmd_ready  = !result_valid || result_ready;
  assign fire       = cmd_valid && cmd_ready;
  assign queue_full = (queued_count == CNT_W'(QUEUE_DEPTH));

  // Tick: debounce, press set tracking and hold or repeat timing.
  always_comb begin
    last_sample_next     = last_sample;
    stable_count_next    = stable_count;
    debounced_state_next = debounced_state;
    pressed_set_next     = pressed_set;
    hold_fired_next      = hold_fired;
    press_age_next       = press_age;
    ev_put               = 1'b0;
    ev_word              = '0;
    if (cmd_kind.tick) begin
      if (cmd_raw == last_sample) begin
        if (stable_count != STABLE_MAX) stable_count_next = stable_count + 1'b1;
      end else begin
        last_sample_next  = cmd_raw;
        stable_count_next = DEBOUNCE_W'(1);
      end
      if (debounced_state != last_sample_next &&
          stable_count_next >= cfg.debounce_ticks) begin
        debounced_state_next = last_sample_next;
        if (last_sample_next != '0) begin
          if (pressed_set == '0 || !hold_fired) begin
            pressed_set_next = pressed_set | last_sample_next;
            press_age_next   = '0;
          end
        end else if (pressed_set != '0) begin
          if (!hold_fired) begin
            ev_put  = 1'b1;
            ev_word = {1'b0, pressed_set};
          end
          hold_fired_next  = 1'b0;
          pressed_set_next = '0;
        end
      end
      if (pressed_set_next != '0 &&
          ((!hold_fired_next && cfg.hold_ticks != '0 &&
            press_age_next >= cfg.hold_ticks) ||
           (hold_fired_next && cfg.repeat_ticks != '0 &&
            press_age_next >= cfg.repeat_ticks))) begin
        hold_fired_next = 1'b1;
        press_age_next  = '0;
        ev_put          = 1'b1;
        ev_word         = {1'b1, pressed_set_next};
      end
      if (press_age_next != AGE_MAX) press_age_next = press_age_next + 1'b1;
    end
  end

  // Queue bookkeeping for puts, pops and clears.
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    queued_count_next  = queued_count;
    mem_we             = 1'b0;
    pop_hit            = 1'b0;
    dropped            = 1'b0;
    priority if (cmd_kind.tick) begin
      if (ev_put) begin
        if (queue_full) begin
          dropped = 1'b1;
        end else begin
          mem_we             = 1'b1;
          write_pointer_next = ptr_inc(write_pointer);
          queued_count_next  = queued_count + 1'b1;
        end
      end
    end else if (cmd_kind.pop) begin
      if (queued_count != '0) begin
        pop_hit           = 1'b1;
        read_pointer_next = ptr_inc(read_pointer);
        queued_count_next = queued_count - 1'b1;
      end
    end else if (cmd_kind.clear) begin
      queued_count_next = '0;
      read_pointer_next = write_pointer;
    end else begin
      queued_count_next = queued_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample     <= '0;
      stable_count    <= '0;
      debounced_state <= '0;
      pressed_set     <= '0;
      hold_fired      <= 1'b0;
      press_age       <= '0;
      write_pointer   <= '0;
      read_pointer    <= '0;
      queued_count    <= '0;
    end else if (fire) begin
      last_sample     <= last_sample_next;
      stable_count    <= stable_count_next;
      debounced_state <= debounced_state_next;
      pressed_set     <= pressed_set_next;
      hold_fired      <= hold_fired_next;
      press_age       <= press_age_next;
      write_pointer   <= write_pointer_next;
      read_pointer    <= read_pointer_next;
      queued_count    <= queued_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we) event_mem[write_pointer] <= ev_word;
  end

  // Result register; the ring buffer read lands here directly.
  always_ff @(posedge clk) begin
    if (fire) begin
      pop_valid         <= pop_hit;
      if (pop_hit) {pop_is_hold, pop_buttons} <= event_mem[read_pointer];
      else         {pop_is_hold, pop_buttons} <= '0;
      debounced_buttons <= debounced_state_next;
      pending_events    <= queued_count_next;
      event_dropped     <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (fire) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queued_count <= CNT_W'(QUEUE_DEPTH))
    else $error("event count above queue depth");

  a_hold_needs_press: assert property (@(posedge clk) disable iff (rst)
    hold_fired |-> (pressed_set != '0))
    else $error("hold flag set with no buttons pressed");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd_kind.clear) |=> (queued_count == '0 && read_pointer == write_pointer))
    else $error("clear left events in the queue");

  a_pop_no_drop: assert property (@(posedge clk) disable iff (rst)
    (result_valid && pop_valid) |-> !event_dropped)
    else $error("a pop reported a dropped event");

endmodule

### design/button_debounce_hold_repeat_events_top.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat_events_top: button debouncer with hold events
// Debounces a button vector, turns presses into click, hold and repeat
// events and queues them for a host to pop.
// ----------------------------------------------------------------------------
// Usage. Each input word carries an opcode and a raw button sample. A tick
// samples the buttons, advances the debouncer and may queue one event; a pop
// takes the oldest event (answering invalid at once if none is queued); a
// clear empties the queue. Every input word yields exactly one result word
// with the pop fields, the debounced state, the queue fill and a flag for an
// event lost to a full queue.
// Throughput is one word per cycle while the receiver keeps taking results. A
// word accepted at the intake is written into the two-entry command queue and
// executed into the result register once the execution side is ready; its
// result word is valid from then on. When the receiver stalls, the result
// register holds its word, the command queue fills, and item_ready drops once
// both queue entries are taken. Configuration (debounce, hold and repeat
// periods) is written on its own channel, always ready; the user must write
// it only while no command is in flight, as the block does not enforce this.
// Reset is synchronous and returns all counters, queue pointers and control
// registers to defaults; the event storage is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat_events_top #(
  parameter int BUTTON_COUNT = bdhr_pkg::BUTTON_COUNT_DEFAULT,
  parameter int QUEUE_DEPTH  = bdhr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdhr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [bdhr_pkg::OPCODE_W-1:0]     opcode,
  input  logic [BUTTON_COUNT-1:0]           raw_buttons,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              pop_valid,
  output logic [BUTTON_COUNT-1:0]           pop_buttons,
  output logic                              pop_is_hold,
  output logic [BUTTON_COUNT-1:0]           debounced_buttons,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  pending_events,
  output logic                              event_dropped
);
  import bdhr_pkg::*;

  cfg_t                    cfg;
  logic                    cmd_valid;
  logic                    cmd_ready;
  cmd_kind_t               cmd_kind;
  logic [BUTTON_COUNT-1:0] cmd_raw;

  // Registers are plain flops; a write to an unused index is accepted and
  // ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.hold_ticks     <= HOLD_RESET;
      cfg.repeat_ticks   <= REPEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DEBOUNCE) cfg.debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
      if (cfg_index == CFG_HOLD)     cfg.hold_ticks     <= cfg_data[AGE_W-1:0];
      if (cfg_index == CFG_REPEAT)   cfg.repeat_ticks   <= cfg_data[AGE_W-1:0];
    end
  end

  bdhr_front #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .opcode      (opcode),
    .raw_buttons (raw_buttons),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_kind    (cmd_kind),
    .cmd_raw     (cmd_raw)
  );

  bdhr_back #(
    .BUTTON_COUNT(BUTTON_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd_kind          (cmd_kind),
    .cmd_raw           (cmd_raw),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .pop_valid         (pop_valid),
    .pop_buttons       (pop_buttons),
    .pop_is_hold       (pop_is_hold),
    .debounced_buttons (debounced_buttons),
    .pending_events    (pending_events),
    .event_dropped     (event_dropped)
  );

endmodule
